### hdl/contiguous_page_allocator_defines.svh
// ----------------------------------------------------------------------------
// Contiguous page allocator assertion macros
// Shared property macros for the allocator checks.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// Contiguous page allocator package
// Sizes, request and status codes, page map entry layout.
// ----------------------------------------------------------------------------
package cpa_pkg;

    localparam int MAP_DEPTH = 1024;
    localparam int PAGE_AW   = $clog2(MAP_DEPTH);
    localparam int CNT_W     = PAGE_AW + 1;
    localparam int CFG_W     = 11;

    typedef logic [1:0] map_entry_t;
    localparam int MAP_TAKEN_BIT = 0;
    localparam int MAP_LAST_BIT  = 1;

    localparam map_entry_t ENTRY_FREE     = 2'b00;
    localparam map_entry_t ENTRY_TAKEN    = 2'b01;
    localparam map_entry_t ENTRY_TAKEN_LS = 2'b11;

    typedef logic [1:0] op_t;
    localparam op_t OP_ALLOC = 2'd0;
    localparam op_t OP_FREE  = 2'd1;
    localparam op_t OP_CLEAR = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NOSPACE = 2'd1;
    localparam status_t ST_BAD     = 2'd2;
    localparam status_t ST_RUNOFF  = 2'd3;

endpackage

### hdl/contiguous_page_allocator.sv
// ----------------------------------------------------------------------------
// Contiguous page allocator
// First-fit allocator over a page map holding a taken and a last bit per page.
// ----------------------------------------------------------------------------
// One request at a time; s_tready is high only while the sequencer is idle.
// All work goes through the page map memory with one write and one read port,
// one entry per cycle, with a registered read pipelined against the scan address.
// Allocate scans to the end of the first fitting run, then writes one entry per
// page of the run. Free rewrites entries from page_index up to the last-marked
// page or the end of the managed pages. Clear writes every entry of the map.
// After reset a clearing pass over all 1024 entries empties the map before the first
// transfer is taken; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`include "contiguous_page_allocator_defines.svh"

module contiguous_page_allocator
    import cpa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,   // pages_managed
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,     // [10:0] page_count, [20:11] page_index
    input  logic [1:0]       s_tuser,     // [1:0] operation
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,     // [9:0] start_page
    output logic [1:0]       m_tuser      // [1:0] status
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCANA = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_SCANF = 3'd4;
    localparam logic [2:0] S_CLEAR = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    map_entry_t page_map_mem [MAP_DEPTH];
    map_entry_t rd_data_reg;

    logic [2:0]         state_reg, state_next;
    logic [CFG_W-1:0]   cfg_reg;
    logic [CNT_W-1:0]   addr_reg, addr_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [CNT_W-1:0]   rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]   run_reg, run_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   end_reg, end_next;
    status_t            res_status_reg, res_status_next;
    logic [PAGE_AW-1:0] res_start_reg, res_start_next;
    logic               m_tvalid_reg, m_tvalid_next;
    status_t            m_status_reg, m_status_next;
    logic [PAGE_AW-1:0] m_start_reg, m_start_next;

    logic               mem_we;
    logic [PAGE_AW-1:0] mem_wa;
    map_entry_t         mem_wd;
    logic [PAGE_AW-1:0] mem_ra;

    logic [CNT_W-1:0]   n_pages;
    logic [CNT_W-1:0]   run_inc;
    logic [CNT_W-1:0]   run_first;
    logic               out_free;
    op_t                in_op;
    logic [CNT_W-1:0]   in_count;
    logic [CNT_W-1:0]   in_index;

    assign n_pages   = (cfg_reg > CFG_W'(MAP_DEPTH)) ? CNT_W'(MAP_DEPTH) : CNT_W'(cfg_reg);
    assign in_op     = s_tuser;
    assign in_count  = s_tdata[10:0];
    assign in_index  = {1'b0, s_tdata[20:11]};
    assign run_inc   = run_reg + 1'b1;
    assign run_first = rd_addr_reg + 1'b1 - count_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(16 - PAGE_AW){1'b0}}, m_start_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            page_map_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= page_map_mem[mem_ra];
    end

    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        rd_valid_next   = 1'b0;
        rd_addr_next    = rd_addr_reg;
        run_next        = run_reg;
        count_next      = count_reg;
        end_next        = end_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_start_next    = m_start_reg;
        mem_we          = 1'b0;
        mem_wa          = addr_reg[PAGE_AW-1:0];
        mem_wd          = ENTRY_FREE;
        mem_ra          = addr_reg[PAGE_AW-1:0];

        case (state_reg)
            S_INIT, S_CLEAR: begin
                mem_we = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == CNT_W'(MAP_DEPTH - 1)) begin
                    res_status_next = ST_OK;
                    res_start_next  = '0;
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    res_start_next  = '0;
                    res_status_next = ST_BAD;
                    run_next        = '0;
                    count_next      = in_count;
                    state_next      = S_DONE;
                    case (in_op)
                        OP_ALLOC: begin
                            addr_next = '0;
                            if (in_count == '0) begin
                                res_status_next = ST_BAD;
                            end else if (n_pages == '0) begin
                                res_status_next = ST_NOSPACE;
                            end else begin
                                state_next = S_SCANA;
                            end
                        end
                        OP_FREE: begin
                            addr_next = in_index;
                            if (in_index < n_pages) begin
                                state_next = S_SCANF;
                            end
                        end
                        OP_CLEAR: begin
                            addr_next  = '0;
                            state_next = S_CLEAR;
                        end
                        default: begin
                            res_status_next = ST_BAD;
                        end
                    endcase
                end
            end
            S_SCANA: begin
                if (addr_reg < n_pages) begin
                    rd_valid_next = 1'b1;
                    rd_addr_next  = addr_reg;
                    addr_next     = addr_reg + 1'b1;
                end
                if (rd_valid_reg) begin
                    if (rd_data_reg[MAP_TAKEN_BIT]) begin
                        run_next = '0;
                    end else begin
                        run_next = run_inc;
                    end
                    if (!rd_data_reg[MAP_TAKEN_BIT] && run_inc == count_reg) begin
                        rd_valid_next  = 1'b0;
                        addr_next      = run_first;
                        end_next       = rd_addr_reg;
                        res_start_next = run_first[PAGE_AW-1:0];
                        state_next     = S_MARK;
                    end else if (rd_addr_reg == n_pages - 1'b1) begin
                        rd_valid_next   = 1'b0;
                        res_status_next = ST_NOSPACE;
                        state_next      = S_DONE;
                    end
                end
            end
            S_MARK: begin
                mem_we    = 1'b1;
                mem_wd    = (addr_reg == end_reg) ? ENTRY_TAKEN_LS : ENTRY_TAKEN;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == end_reg) begin
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end
            end
            S_SCANF: begin
                if (addr_reg < n_pages) begin
                    rd_valid_next = 1'b1;
                    rd_addr_next  = addr_reg;
                    addr_next     = addr_reg + 1'b1;
                end
                if (rd_valid_reg) begin
                    mem_we = 1'b1;
                    mem_wa = rd_addr_reg[PAGE_AW-1:0];
                    if (rd_data_reg[MAP_LAST_BIT]) begin
                        rd_valid_next   = 1'b0;
                        res_status_next = ST_OK;
                        state_next      = S_DONE;
                    end else if (rd_addr_reg == n_pages - 1'b1) begin
                        rd_valid_next   = 1'b0;
                        res_status_next = ST_RUNOFF;
                        state_next      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_start_next  = res_start_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            cfg_reg      <= CFG_W'(1024);
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            rd_valid_reg <= rd_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg    <= rd_addr_next;
        run_reg        <= run_next;
        count_reg      <= count_next;
        end_reg        <= end_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        m_status_reg   <= m_status_next;
        m_start_reg    <= m_start_next;
    end

    `CPA_ASSERT_IMP(a_idle_no_write, state_reg == S_IDLE, !mem_we, "page map written while idle")
    `CPA_ASSERT_IMP(a_mark_order, state_reg == S_MARK, addr_reg <= end_reg, "mark ran past run end")
    `CPA_ASSERT_IMP(a_run_bound, state_reg == S_SCANA, run_reg < count_reg, "run length overshoot")
    `CPA_ASSERT_IMP(a_start_zero, m_tvalid && (m_tuser != ST_OK), m_tdata == '0,
                    "start page set on failed request")

endmodule

### tb/contiguous_page_allocator_test.sv
// ----------------------------------------------------------------------------
// Contiguous page allocator testbench
// Drives allocate, free, clear and illegal requests over several heap sizes,
// predicts each response from a local copy of the page map and checks every
// response transfer in order, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module contiguous_page_allocator_test;
    import cpa_pkg::*;

    localparam op_t OP_UNDEF = 2'd3;

    typedef struct packed {
        status_t            status;
        logic [PAGE_AW-1:0] start_page;
    } alloc_result_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [23:0]      s_tdata;
    logic [1:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [15:0]      m_tdata;
    logic [1:0]       m_tuser;

    map_entry_t         heap_map [MAP_DEPTH];
    logic [CFG_W-1:0]   heap_pages;
    alloc_result_t      awaited_responses [$];
    logic [PAGE_AW-1:0] live_starts [$];
    int unsigned        failures = 0;
    bit                 source_gaps = 1'b0;
    bit                 sink_stalls = 1'b0;
    int unsigned        hold_off_cycles = 0;

    always #6 aclk = ~aclk;

    contiguous_page_allocator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    function automatic int unsigned idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 48);
    endfunction

    // first-fit search, free up to the last-marked page, clear
    function automatic alloc_result_t heap_response(op_t op, logic [CNT_W-1:0] count,
                                                    logic [PAGE_AW-1:0] index);
        alloc_result_t r;
        int            span;
        int            run;
        int            first;
        int            p;
        bit            done;
        map_entry_t    was;
        r.status     = ST_BAD;
        r.start_page = '0;
        span = (heap_pages > MAP_DEPTH) ? MAP_DEPTH : int'(heap_pages);
        done = 1'b0;
        run  = 0;
        case (op)
            OP_ALLOC: begin
                if (count != 0) begin
                    r.status = ST_NOSPACE;
                    for (p = 0; p < span && !done; p++) begin
                        if (heap_map[p][MAP_TAKEN_BIT]) begin
                            run = 0;
                        end else begin
                            run++;
                            if (run >= int'(count)) begin
                                first = p + 1 - int'(count);
                                for (int k = first; k <= p; k++) begin
                                    heap_map[k][MAP_TAKEN_BIT] = 1'b1;
                                end
                                heap_map[p][MAP_LAST_BIT] = 1'b1;
                                r.status     = ST_OK;
                                r.start_page = PAGE_AW'(first);
                                done = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_FREE: begin
                if (int'(index) < span) begin
                    r.status = ST_RUNOFF;
                    for (p = int'(index); p < span && !done; p++) begin
                        was = heap_map[p];
                        heap_map[p] = ENTRY_FREE;
                        if (was[MAP_LAST_BIT]) begin
                            r.status = ST_OK;
                            done = 1'b1;
                        end
                    end
                end
            end
            OP_CLEAR: begin
                foreach (heap_map[i]) begin
                    heap_map[i] = ENTRY_FREE;
                end
                r.status = ST_OK;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(op_t op, logic [CNT_W-1:0] count, logic [PAGE_AW-1:0] index);
        alloc_result_t want;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, index, count};
        do @(posedge aclk); while (!s_tready);
        want = heap_response(op, count, index);
        awaited_responses.push_back(want);
        if (op == OP_ALLOC && want.status == ST_OK) begin
            live_starts.push_back(want.start_page);
        end
        if (op == OP_CLEAR) begin
            live_starts.delete();
        end
        if (source_gaps && $urandom_range(0, 1) == 0) begin
            s_tvalid <= 1'b0;
            repeat (idle_length()) @(posedge aclk);
        end
    endtask

    task automatic wait_for_results(int unsigned settle);
        s_tvalid <= 1'b0;
        while (awaited_responses.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_pages_managed(logic [CFG_W-1:0] value);
        wait_for_results(16);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        heap_pages = value;
    endtask

    task automatic send_random_request(int unsigned span);
        int unsigned        pick;
        int unsigned        slot;
        logic [CNT_W-1:0]   count;
        logic [PAGE_AW-1:0] index;
        pick  = $urandom_range(0, 99);
        count = CNT_W'($urandom_range(0, 2047));
        index = PAGE_AW'($urandom_range(0, 1023));
        if (pick < 48) begin
            if ($urandom_range(0, 9) != 0) begin
                count = CNT_W'($urandom_range(1, (span + 3) / 4));
            end
            send_request(OP_ALLOC, count, index);
        end else if (pick < 83 && live_starts.size() != 0) begin
            slot  = $urandom_range(0, live_starts.size() - 1);
            index = live_starts[slot];
            live_starts.delete(slot);
            send_request(OP_FREE, count, index);
        end else if (pick < 94) begin
            if (pick % 2 == 0) begin
                index = PAGE_AW'($urandom_range(0, span - 1));
            end
            send_request(OP_FREE, count, index);
        end else if (pick < 97) begin
            send_request(OP_CLEAR, count, index);
        end else begin
            send_request(OP_UNDEF, count, index);
        end
    endtask

    // reset size: whole-heap run, zero and oversize counts, illegal op
    task automatic test_full_heap();
        send_request(OP_ALLOC, CNT_W'(MAP_DEPTH), '0);
        send_request(OP_ALLOC, CNT_W'(1), '0);
        send_request(OP_FREE, '0, '0);
        send_request(OP_ALLOC, '0, '1);
        send_request(OP_ALLOC, '1, '0);
        send_request(OP_UNDEF, '1, '1);
        send_request(OP_FREE, '1, '1);
    endtask

    // mid-run free, free of untaken pages, index out of range, clear
    task automatic test_small_heap();
        write_pages_managed(CFG_W'(16));
        send_request(OP_ALLOC, CNT_W'(3), '0);
        send_request(OP_ALLOC, CNT_W'(5), '0);
        send_request(OP_FREE, '0, PAGE_AW'(1));
        send_request(OP_ALLOC, CNT_W'(2), '0);
        send_request(OP_FREE, '0, PAGE_AW'(8));
        send_request(OP_FREE, '0, PAGE_AW'(16));
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_ALLOC, CNT_W'(16), '0);
    endtask

    // empty heap, clamped size, pages kept beyond the managed count
    task automatic test_managed_extremes();
        write_pages_managed('0);
        send_request(OP_ALLOC, CNT_W'(1), '0);
        send_request(OP_FREE, '0, '0);
        write_pages_managed('1);
        send_request(OP_ALLOC, CNT_W'(MAP_DEPTH - 16), '0);
        write_pages_managed(CFG_W'(8));
        send_request(OP_FREE, '0, '0);
        write_pages_managed(CFG_W'(MAP_DEPTH));
        send_request(OP_ALLOC, CNT_W'(1), '0);
        send_request(OP_FREE, '0, PAGE_AW'(8));
        write_pages_managed(CFG_W'(1));
        send_request(OP_ALLOC, CNT_W'(1), '0);
        send_request(OP_FREE, '0, '0);
        send_request(OP_ALLOC, CNT_W'(1), '0);
        send_request(OP_CLEAR, '0, '0);
    endtask

    // output held off while requests keep coming, then sender waits it out
    task automatic test_backpressure();
        write_pages_managed(CFG_W'(16));
        source_gaps     = 1'b0;
        sink_stalls     = 1'b0;
        hold_off_cycles = 300;
        repeat (6) send_request(OP_ALLOC, CNT_W'(2), '0);
        wait_for_results(0);
    endtask

    task automatic test_random_traffic();
        int unsigned phase_pages [8] = '{32, 64, 5, 1, 200, 1024, 2047, 48};
        int unsigned phase_items [8] = '{100, 100, 60, 40, 90, 30, 30, 90};
        int unsigned span;
        foreach (phase_pages[ph]) begin
            write_pages_managed(CFG_W'(phase_pages[ph]));
            span = (phase_pages[ph] > MAP_DEPTH) ? MAP_DEPTH : phase_pages[ph];
            source_gaps = 1'($urandom_range(0, 1));
            sink_stalls = 1'($urandom_range(0, 1));
            send_request(OP_CLEAR, CNT_W'($urandom), PAGE_AW'($urandom));
            repeat (phase_items[ph]) begin
                if ($urandom_range(0, 24) == 0) begin
                    source_gaps = !source_gaps;
                end
                if ($urandom_range(0, 24) == 0) begin
                    sink_stalls = !sink_stalls;
                end
                send_random_request(span);
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_ALLOC;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (heap_map[i]) begin
            heap_map[i] = ENTRY_FREE;
        end
        heap_pages = CFG_W'(MAP_DEPTH);
        test_full_heap();
        test_small_heap();
        test_managed_extremes();
        test_backpressure();
        test_random_traffic();
        wait_for_results(64);
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : result_sink
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_off_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge aclk);
                hold_off_cycles = 0;
            end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (idle_length()) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_responses.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, got status %0d start %0d",
                         $time, m_tuser, m_tdata[PAGE_AW-1:0]);
                failures++;
            end else begin
                want = awaited_responses.pop_front();
                if (m_tuser !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, m_tuser);
                    failures++;
                end
                if (m_tdata[PAGE_AW-1:0] !== want.start_page) begin
                    $display("%0t: start_page mismatch, expected %0d, got %0d",
                             $time, want.start_page, m_tdata[PAGE_AW-1:0]);
                    failures++;
                end
            end
        end
    end

    initial begin
        #(12 * 7_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
